/* design/swdh_pkg.sv */
// package for the swd host transfer engine: codes, state and result types
`timescale 1ns / 1ps
`default_nettype none

package swdh_pkg;

    // idle clocks after a transfer and after each line reset of the connect sequence
    localparam int IDLE_CLOCKS = 8;
    // ones in one line reset
    localparam int RESET_ONES  = 64;
    // bits in the request header, the ack, the data word, the select word
    localparam int REQ_BITS    = 8;
    localparam int ACK_BITS    = 3;
    localparam int DATA_BITS   = 32;
    localparam int SEL_BITS    = 16;

    // bit counter must hold the longest phase length itself
    localparam int LONGEST = (RESET_ONES > IDLE_CLOCKS) ? RESET_ONES : IDLE_CLOCKS;
    localparam int CNT_W   = $clog2(LONGEST + 1);

    localparam logic [SEL_BITS-1:0] SEL_WORD = 16'hE79E;
    localparam logic [7:0] REQ_FIXED = 8'h81;

    // item kinds
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_XFER    = 2'd1;
    localparam logic [1:0] KIND_CONNECT = 2'd2;

    // ack codes
    localparam logic [2:0] ACK_OK    = 3'd1;
    localparam logic [2:0] ACK_STALL = 3'd2;

    // completion status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FAULT    = 2'd1;
    localparam logic [1:0] ST_PARITY   = 2'd2;
    localparam logic [1:0] ST_WAIT_OUT = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_REQ     = 4'd1,
        PH_TRN_IN  = 4'd2,
        PH_ACK     = 4'd3,
        PH_TRN_OUT = 4'd4,
        PH_RDATA   = 4'd5,
        PH_RPAR    = 4'd6,
        PH_WDATA   = 4'd7,
        PH_WPAR    = 4'd8,
        PH_IDLECLK = 4'd9,
        PH_RST1    = 4'd10,
        PH_IDLE1   = 4'd11,
        PH_SEL     = 4'd12,
        PH_RST2    = 4'd13,
        PH_IDLE2   = 4'd14
    } t_phase;

    typedef struct packed {
        t_phase                phase;
        logic [CNT_W-1:0]      bit_cnt;
        logic [7:0]            req_byte;
        logic [DATA_BITS-1:0]  wr_word;
        logic [DATA_BITS-1:0]  rd_shift;
        logic [ACK_BITS-1:0]   ack;
        logic [7:0]            attempts;
        logic                  is_read;
        logic [1:0]            pend_status;
    } t_state;

    // result of one transaction, packed lowest field last
    typedef struct packed {
        logic [DATA_BITS-1:0] rd_data;
        logic [1:0]           status;
        logic                 done;
        logic                 busy;
        logic                 line_enable;
        logic                 line_drive;
        logic                 clock_pulse;
    } t_result;

    localparam int RES_W = $bits(t_result);

endpackage

`default_nettype wire

/* design/swdh_step.sv */
// next-state and result logic for one input transaction of the swd engine
`timescale 1ns / 1ps
`default_nettype none

module swdh_step (
    input  var swdh_pkg::t_state         i_cur,
    input  wire [7:0]                    i_retry_limit,
    input  wire [1:0]                    i_kind,
    input  wire                          i_ap_access,
    input  wire                          i_read_access,
    input  wire [1:0]                    i_reg_select,
    input  wire [swdh_pkg::DATA_BITS-1:0] i_wr_data,
    input  wire                          i_line_sample,
    output swdh_pkg::t_state             o_next,
    output swdh_pkg::t_result            o_res
);

    logic [swdh_pkg::CNT_W-1:0] cnt_inc;
    logic [7:0]                 req_new;
    logic                       req_par;
    logic [7:0]                 lim;
    logic [8:0]                 att_inc;
    logic                       done;

    // header byte: start, APnDP, RnW, A2, A3, parity, stop, park
    assign req_par = i_ap_access ^ i_read_access ^ i_reg_select[0] ^ i_reg_select[1];
    assign req_new = swdh_pkg::REQ_FIXED
                   | {2'b00, req_par, i_reg_select[1], i_reg_select[0],
                      i_read_access, i_ap_access, 1'b0};
    assign cnt_inc = i_cur.bit_cnt + 1'b1;
    // a zero limit still allows one attempt
    assign lim     = (i_retry_limit == 8'd0) ? 8'd1 : i_retry_limit;
    assign att_inc = {1'b0, i_cur.attempts} + 9'd1;

    always_comb begin
        o_next = i_cur;
        o_res  = '0;
        done   = 1'b0;

        if (i_cur.phase == swdh_pkg::PH_IDLE && i_kind == swdh_pkg::KIND_XFER) begin
            // load a new access
            o_next.req_byte    = req_new;
            o_next.wr_word     = i_wr_data;
            o_next.rd_shift    = '0;
            o_next.is_read     = i_read_access;
            o_next.attempts    = '0;
            o_next.phase       = swdh_pkg::PH_REQ;
            o_next.bit_cnt     = '0;
            o_next.ack         = '0;
            o_next.pend_status = swdh_pkg::ST_OK;
        end else if (i_cur.phase == swdh_pkg::PH_IDLE
                     && i_kind == swdh_pkg::KIND_CONNECT) begin
            // connect sequence starts with a line reset
            o_next.is_read     = 1'b0;
            o_next.pend_status = swdh_pkg::ST_OK;
            o_next.bit_cnt     = '0;
            o_next.phase       = swdh_pkg::PH_RST1;
        end else if (i_kind == swdh_pkg::KIND_TICK && i_cur.phase != swdh_pkg::PH_IDLE) begin
            o_res.clock_pulse = 1'b1;
            case (i_cur.phase)
                swdh_pkg::PH_REQ: begin
                    o_res.line_enable = 1'b1;
                    o_res.line_drive  = i_cur.req_byte[i_cur.bit_cnt[2:0]];
                    o_next.bit_cnt    = cnt_inc;
                    if (cnt_inc >= swdh_pkg::CNT_W'(swdh_pkg::REQ_BITS)) begin
                        o_next.bit_cnt = '0;
                        o_next.phase   = swdh_pkg::PH_TRN_IN;
                    end
                end
                swdh_pkg::PH_TRN_IN: begin
                    o_next.bit_cnt = '0;
                    o_next.phase   = swdh_pkg::PH_ACK;
                end
                swdh_pkg::PH_ACK: begin
                    o_next.ack[i_cur.bit_cnt[1:0]] =
                        i_cur.ack[i_cur.bit_cnt[1:0]] | i_line_sample;
                    o_next.bit_cnt = cnt_inc;
                    if (cnt_inc >= swdh_pkg::CNT_W'(swdh_pkg::ACK_BITS)) begin
                        o_next.bit_cnt = '0;
                        if (o_next.ack == swdh_pkg::ACK_OK) begin
                            o_next.phase = i_cur.is_read ? swdh_pkg::PH_RDATA
                                                         : swdh_pkg::PH_TRN_OUT;
                        end else begin
                            if (o_next.ack != swdh_pkg::ACK_STALL) begin
                                o_next.pend_status = swdh_pkg::ST_FAULT;
                            end
                            o_next.phase = swdh_pkg::PH_TRN_OUT;
                        end
                    end
                end
                swdh_pkg::PH_TRN_OUT: begin
                    o_next.bit_cnt = '0;
                    o_next.phase   = (i_cur.ack == swdh_pkg::ACK_OK && !i_cur.is_read)
                                   ? swdh_pkg::PH_WDATA : swdh_pkg::PH_IDLECLK;
                end
                swdh_pkg::PH_RDATA: begin
                    o_next.rd_shift[i_cur.bit_cnt[4:0]] =
                        i_cur.rd_shift[i_cur.bit_cnt[4:0]] | i_line_sample;
                    o_next.bit_cnt = cnt_inc;
                    if (cnt_inc >= swdh_pkg::CNT_W'(swdh_pkg::DATA_BITS)) begin
                        o_next.bit_cnt = '0;
                        o_next.phase   = swdh_pkg::PH_RPAR;
                    end
                end
                swdh_pkg::PH_RPAR: begin
                    if (i_line_sample != ^i_cur.rd_shift) begin
                        o_next.pend_status = swdh_pkg::ST_PARITY;
                    end
                    o_next.bit_cnt = '0;
                    o_next.phase   = swdh_pkg::PH_TRN_OUT;
                end
                swdh_pkg::PH_WDATA: begin
                    o_res.line_enable = 1'b1;
                    o_res.line_drive  = i_cur.wr_word[i_cur.bit_cnt[4:0]];
                    o_next.bit_cnt    = cnt_inc;
                    if (cnt_inc >= swdh_pkg::CNT_W'(swdh_pkg::DATA_BITS)) begin
                        o_next.bit_cnt = '0;
                        o_next.phase   = swdh_pkg::PH_WPAR;
                    end
                end
                swdh_pkg::PH_WPAR: begin
                    o_res.line_enable = 1'b1;
                    o_res.line_drive  = ^i_cur.wr_word;
                    o_next.bit_cnt    = '0;
                    o_next.phase      = swdh_pkg::PH_IDLECLK;
                end
                swdh_pkg::PH_IDLECLK: begin
                    o_res.line_enable = 1'b1;
                    o_next.bit_cnt    = cnt_inc;
                    if (cnt_inc >= swdh_pkg::CNT_W'(swdh_pkg::IDLE_CLOCKS)) begin
                        o_next.bit_cnt = '0;
                        if (i_cur.ack == swdh_pkg::ACK_STALL) begin
                            // retry unless the attempt budget is used up
                            o_next.attempts = att_inc[7:0];
                            if (att_inc >= {1'b0, lim}) begin
                                o_next.pend_status = swdh_pkg::ST_WAIT_OUT;
                                done = 1'b1;
                            end else begin
                                o_next.phase       = swdh_pkg::PH_REQ;
                                o_next.ack         = '0;
                                o_next.pend_status = swdh_pkg::ST_OK;
                            end
                        end else begin
                            done = 1'b1;
                        end
                    end
                end
                swdh_pkg::PH_RST1, swdh_pkg::PH_RST2: begin
                    o_res.line_enable = 1'b1;
                    o_res.line_drive  = 1'b1;
                    o_next.bit_cnt    = cnt_inc;
                    if (cnt_inc >= swdh_pkg::CNT_W'(swdh_pkg::RESET_ONES)) begin
                        o_next.bit_cnt = '0;
                        o_next.phase   = (i_cur.phase == swdh_pkg::PH_RST1)
                                       ? swdh_pkg::PH_IDLE1 : swdh_pkg::PH_IDLE2;
                    end
                end
                swdh_pkg::PH_IDLE1: begin
                    o_res.line_enable = 1'b1;
                    o_next.bit_cnt    = cnt_inc;
                    if (cnt_inc >= swdh_pkg::CNT_W'(swdh_pkg::IDLE_CLOCKS)) begin
                        o_next.bit_cnt = '0;
                        o_next.phase   = swdh_pkg::PH_SEL;
                    end
                end
                swdh_pkg::PH_SEL: begin
                    o_res.line_enable = 1'b1;
                    o_res.line_drive  = swdh_pkg::SEL_WORD[i_cur.bit_cnt[3:0]];
                    o_next.bit_cnt    = cnt_inc;
                    if (cnt_inc >= swdh_pkg::CNT_W'(swdh_pkg::SEL_BITS)) begin
                        o_next.bit_cnt = '0;
                        o_next.phase   = swdh_pkg::PH_RST2;
                    end
                end
                default: begin
                    // final idle clocks of the connect sequence; any other phase finishes at once
                    o_res.line_enable = 1'b1;
                    o_next.bit_cnt    = cnt_inc;
                    if (i_cur.phase != swdh_pkg::PH_IDLE2
                        || cnt_inc >= swdh_pkg::CNT_W'(swdh_pkg::IDLE_CLOCKS)) begin
                        o_next.bit_cnt     = '0;
                        o_next.pend_status = swdh_pkg::ST_OK;
                        o_next.is_read     = 1'b0;
                        done               = 1'b1;
                    end
                end
            endcase

            // finish: report status and read data
            if (done) begin
                o_next.phase = swdh_pkg::PH_IDLE;
                o_res.done   = 1'b1;
                o_res.status = o_next.pend_status;
                if (o_next.is_read && o_next.pend_status == swdh_pkg::ST_OK) begin
                    o_res.rd_data = o_next.rd_shift;
                end
            end
        end

        o_res.busy = (o_next.phase != swdh_pkg::PH_IDLE);
    end

endmodule

`default_nettype wire

/* design/swd_host_transfer_engine.sv */
// top level of the swd host transfer engine: handshake, state and result registers
// a result is registered and appears in the cycle after its input transaction is accepted
// throughput: one transaction per cycle while the result side does not stall; one accepted tick is one swd bit period
// the input is ready whenever the result register is empty or being drained
// reset (synchronous, active low): phase idle, all state zero, retry limit 32,
// no result pending
`timescale 1ns / 1ps
`default_nettype none

module swd_host_transfer_engine (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // retry limit register write
    input  wire        i_cfg_we,
    input  wire [7:0]  i_cfg_wdata,
    // input items
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    // [0] ap_access, [1] read_access, [3:2] reg_select, [35:4] wr_data,
    // [36] line_sample, [39:37] zero
    input  wire [39:0] s_axis_tdata,
    // [1:0] kind
    input  wire [1:0]  s_axis_tuser,
    // result items
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    // [0] clock_pulse, [1] line_drive, [2] line_enable, [3] busy_res,
    // [4] done_res, [6:5] status, [38:7] rd_data, [39] zero
    output logic [39:0] m_axis_tdata
);

    swdh_pkg::t_state  r_state;
    swdh_pkg::t_state  n_state;
    swdh_pkg::t_result step_res;
    swdh_pkg::t_result r_res;
    logic              r_out_valid;
    logic [7:0]        r_retry_limit;
    logic              in_take;

    // accept while the result register is free or being emptied
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // combinational work for one transaction
    swdh_step u_step (
        .i_cur         (r_state),
        .i_retry_limit (r_retry_limit),
        .i_kind        (s_axis_tuser),
        .i_ap_access   (s_axis_tdata[0]),
        .i_read_access (s_axis_tdata[1]),
        .i_reg_select  (s_axis_tdata[3:2]),
        .i_wr_data     (s_axis_tdata[35:4]),
        .i_line_sample (s_axis_tdata[36]),
        .o_next        (n_state),
        .o_res         (step_res)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= 8'd32;
        end else if (i_cfg_we) begin
            r_retry_limit <= i_cfg_wdata;
        end
    end

    // engine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= '0;
            r_state.phase <= swdh_pkg::PH_IDLE;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_res <= step_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(40 - swdh_pkg::RES_W){1'b0}}, r_res};

endmodule

`default_nettype wire
